// ===== rtl/slwsl_pkg.sv =====
// Shared types and constants for the segmented longest window sum block.
// No dependencies.
package slwsl_pkg;

	localparam int HEIGHT_W = 30;
	localparam int VALUE_W  = 30;
	localparam int LIMIT_W  = 48;
	localparam int RUN_W    = 11;
	localparam int REM_CNT_W = $clog2(HEIGHT_W);
	localparam logic [RUN_W-1:0] RUN_MAX = 11'd2047;

	// window datapath commands, driven from the sequencer steps
	typedef struct packed {
		logic clear;
		logic push;
		logic new_seg;
		logic rd;
		logic pop;
	} win_cmd_t;

endpackage

// ===== rtl/slwsl_rem.sv =====
// Radix-2 restoring remainder unit: one compare-subtract per cycle while busy.
// Depends on slwsl_pkg.
module slwsl_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [slwsl_pkg::HEIGHT_W-1:0] dividend,
	input  logic [slwsl_pkg::HEIGHT_W-1:0] divisor,
	output logic                          done,
	output logic                          rem_nz
);
	localparam int W = slwsl_pkg::HEIGHT_W;
	localparam int CW = slwsl_pkg::REM_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			if (!diff[W])
				rem_q <= diff[W-1:0];
			else
				rem_q <= trial[W-1:0];
		end
	end

	assign done   = done_q;
	assign rem_nz = (rem_q != '0);

endmodule

// ===== rtl/slwsl_window.sv =====
// Sliding window store with head, length and running sum.
// Depends on slwsl_pkg.
module slwsl_window #(
	parameter int MAX_ITEMS = 1024,
	parameter int VW        = 30,
	parameter int IDX_W     = 10,
	parameter int LEN_W     = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slwsl_pkg::win_cmd_t           cmd,
	input  logic [VW-1:0]                 value,
	input  logic [slwsl_pkg::LIMIT_W-1:0] limit,
	output logic [LEN_W-1:0]              len,
	output logic                          over
);
	localparam int SUM_W = VW + LEN_W;
	localparam int CMP_W = (SUM_W > slwsl_pkg::LIMIT_W) ? SUM_W : slwsl_pkg::LIMIT_W;
	localparam logic [LEN_W:0] MAX_X = (LEN_W+1)'(MAX_ITEMS);

	logic [VW-1:0]    mem [MAX_ITEMS];
	logic [VW-1:0]    rd_q;
	logic [IDX_W-1:0] head_q;
	logic [LEN_W-1:0] len_q;
	logic [SUM_W-1:0] sum_q;

	logic [IDX_W-1:0] head_e;
	logic [LEN_W-1:0] len_e;
	logic [SUM_W-1:0] sum_e;
	logic [LEN_W:0]   tail_raw;
	logic [LEN_W:0]   tail_w;
	logic [LEN_W:0]   head_inc;
	logic [IDX_W-1:0] head_nxt;

	always_comb begin
		head_e   = cmd.new_seg ? '0 : head_q;
		len_e    = cmd.new_seg ? '0 : len_q;
		sum_e    = cmd.new_seg ? '0 : sum_q;
		tail_raw = (LEN_W+1)'(head_e) + (LEN_W+1)'(len_e);
		tail_w   = (tail_raw >= MAX_X) ? tail_raw - MAX_X : tail_raw;
		head_inc = (LEN_W+1)'(head_q) + 1'b1;
		head_nxt = (head_inc >= MAX_X) ? '0 : head_inc[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			len_q  <= '0;
			sum_q  <= '0;
		end else if (cmd.clear) begin
			head_q <= '0;
			len_q  <= '0;
			sum_q  <= '0;
		end else if (cmd.push) begin
			head_q <= head_e;
			len_q  <= len_e + 1'b1;
			sum_q  <= sum_e + SUM_W'(value);
		end else if (cmd.pop) begin
			head_q <= head_nxt;
			len_q  <= len_q - 1'b1;
			sum_q  <= sum_q - SUM_W'(rd_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[tail_w[IDX_W-1:0]] <= value;
		if (cmd.rd)
			rd_q <= mem[head_q];
	end

	assign len  = len_q;
	assign over = CMP_W'(sum_q) > CMP_W'(limit);

endmodule

// ===== rtl/segmented_longest_window_sum_limit.sv =====
// Top level: sequencer, configuration register and result register.
// Depends on slwsl_pkg, slwsl_rem, slwsl_window.
//
// Input channel (in_valid/in_stall) carries one beat per item: item_value,
// item_height and last_item. Output channel (out_valid/out_stall) carries one
// beat per sequence: longest_run and overflow, sent after the last item.
// An item with a divisibility test passes through the serial remainder step,
// then push, check, a pop when the window is over the limit, finish and back
// to idle; the first item of a segment or a zero height skips the remainder
// step. in_stall is held high meanwhile. Items past MAX_ITEMS in a sequence
// go from idle straight to the finish step.
// The result beat is registered from the finish step of the last item.
// The output register lets the next sequence start while a result waits; a
// second last item stalls in its finish step until that result is taken.
// sum_limit is written through cfg_we/cfg_data; the user must write it only while
// the block is idle, as the block itself does not enforce this. Reset clears the
// sequence state, limit and valid flag; the window store needs no clearing pass.
module segmented_longest_window_sum_limit #(
	parameter int MAX_ITEMS  = 1024,
	parameter int VALUE_BITS = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [slwsl_pkg::LIMIT_W-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [slwsl_pkg::VALUE_W-1:0]     item_value,
	input  logic [slwsl_pkg::HEIGHT_W-1:0]    item_height,
	input  logic                              last_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [slwsl_pkg::RUN_W-1:0]       longest_run,
	output logic                              overflow
);
	localparam int VW    = (VALUE_BITS < slwsl_pkg::VALUE_W) ? VALUE_BITS : slwsl_pkg::VALUE_W;
	localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int LEN_W = $clog2(MAX_ITEMS + 1);
	localparam int RW    = (LEN_W > slwsl_pkg::RUN_W) ? LEN_W : slwsl_pkg::RUN_W;
	localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_ITEMS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_PUSH  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_POP   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]                        state_q;
	logic [slwsl_pkg::LIMIT_W-1:0]     limit_q;
	logic [slwsl_pkg::HEIGHT_W-1:0]    prev_q;
	logic                              first_q;
	logic [LEN_W-1:0]                  count_q;
	logic [LEN_W-1:0]                  best_q;
	logic                              ovf_q;
	logic                              newseg_q;
	logic                              last_q;
	logic [VW-1:0]                     val_q;
	logic                              out_valid_q;
	logic [slwsl_pkg::RUN_W-1:0]       run_q;
	logic                              ovf_out_q;

	logic                              accept;
	logic                              rem_start;
	logic                              rem_done;
	logic                              rem_nz;
	logic                              over;
	logic [LEN_W-1:0]                  win_len;
	slwsl_pkg::win_cmd_t               cmd;
	logic                              can_emit;
	logic                              emit;
	logic [RW-1:0]                     best_ext;
	logic [slwsl_pkg::RUN_W-1:0]       run_sat;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign rem_start = accept && (count_q < MAX_L) && !first_q && (item_height != '0);
	assign can_emit  = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_FIN) && last_q && can_emit;

	always_comb begin
		best_ext = RW'(best_q);
		run_sat  = (best_ext > RW'(slwsl_pkg::RUN_MAX)) ? slwsl_pkg::RUN_MAX
			: best_ext[slwsl_pkg::RUN_W-1:0];
	end

	always_comb begin
		cmd         = '0;
		cmd.push    = (state_q == ST_PUSH);
		cmd.new_seg = (state_q == ST_PUSH) && newseg_q;
		cmd.rd      = (state_q == ST_CHECK) && over;
		cmd.pop     = (state_q == ST_POP);
		cmd.clear   = emit;
	end

	slwsl_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (prev_q),
		.divisor  (item_height),
		.done     (rem_done),
		.rem_nz   (rem_nz)
	);

	slwsl_window #(
		.MAX_ITEMS (MAX_ITEMS),
		.VW        (VW),
		.IDX_W     (IDX_W),
		.LEN_W     (LEN_W)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (val_q),
		.limit  (limit_q),
		.len    (win_len),
		.over   (over)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			first_q     <= 1'b1;
			count_q     <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			newseg_q    <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_item;
						if (count_q >= MAX_L) begin
							ovf_q   <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							count_q <= count_q + 1'b1;
							prev_q  <= item_height;
							first_q <= 1'b0;
							if (first_q || (item_height == '0)) begin
								newseg_q <= 1'b1;
								state_q  <= ST_PUSH;
							end else begin
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (rem_done) begin
						newseg_q <= rem_nz;
						state_q  <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (over) begin
						state_q <= ST_POP;
					end else begin
						if (win_len > best_q)
							best_q <= win_len;
						state_q <= ST_FIN;
					end
				end
				ST_POP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (can_emit) begin
						prev_q      <= '0;
						first_q     <= 1'b1;
						count_q     <= '0;
						best_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			val_q <= item_value[VW-1:0];
		if (emit) begin
			run_q     <= run_sat;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign longest_run = run_q;
	assign overflow    = ovf_out_q;

	a_len_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		win_len <= count_q)
		else $error("window longer than items taken");

	a_best_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= count_q)
		else $error("best length exceeds items taken");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN && last_q))
		else $error("result beat without a finished last item");

	a_rem_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == ST_DIV))
		else $error("remainder finished outside the divide step");

endmodule

// ===== tb/sv/segmented_longest_window_sum_limit_tb.sv =====
// Self-checking testbench for segmented_longest_window_sum_limit.
// Predicts each sequence's longest in-limit window and overflow flag from the
// accepted beats; depends on slwsl_pkg and the block's RTL.
`timescale 1ns / 100ps

module segmented_longest_window_sum_limit_tb;

	localparam int MAX_ITEMS = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 60;
	localparam int HOLD_CYCLES = 1000;
	localparam logic [slwsl_pkg::VALUE_W-1:0] VALUE_TOP = '1;
	localparam logic [slwsl_pkg::HEIGHT_W-1:0] HEIGHT_TOP = '1;
	localparam logic [slwsl_pkg::LIMIT_W-1:0] LIMIT_TOP = '1;

	typedef struct packed {
		logic [slwsl_pkg::VALUE_W-1:0]  value;
		logic [slwsl_pkg::HEIGHT_W-1:0] height;
		logic                           last;
	} item_t;

	typedef struct packed {
		logic [slwsl_pkg::RUN_W-1:0] run;
		logic                        ovf;
	} run_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [slwsl_pkg::LIMIT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [slwsl_pkg::VALUE_W-1:0] item_value = '0;
	logic [slwsl_pkg::HEIGHT_W-1:0] item_height = '0;
	logic last_item = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [slwsl_pkg::RUN_W-1:0] longest_run;
	logic overflow;

	segmented_longest_window_sum_limit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.item_value(item_value),
		.item_height(item_height),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.longest_run(longest_run),
		.overflow(overflow)
	);

	item_t pending_items[$];
	run_res_t expected_runs[$];
	item_t cur_item;
	run_res_t want_run;

	// predictor state
	logic [slwsl_pkg::LIMIT_W-1:0] lim = '0;
	logic [slwsl_pkg::HEIGHT_W-1:0] prev_h;
	logic seg_open;
	logic [slwsl_pkg::VALUE_W-1:0] win_vals[MAX_ITEMS];
	logic [9:0] win_head;
	logic [slwsl_pkg::RUN_W-1:0] win_len;
	logic [63:0] win_sum;
	logic [slwsl_pkg::RUN_W-1:0] best_len;
	logic ovf_seen;
	int taken_cnt;

	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int mismatches = 0;
	int items_taken = 0;
	int results_checked = 0;
	int ovf_results = 0;
	int limits_used = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic clear_seq();
		prev_h = '0;
		seg_open = 1'b1;
		win_head = '0;
		win_len = '0;
		win_sum = '0;
		best_len = '0;
		ovf_seen = 1'b0;
		taken_cnt = 0;
	endtask

	task automatic predict_item(input item_t it);
		logic seg_new;
		logic [9:0] tail;
		run_res_t res;
		if (taken_cnt >= MAX_ITEMS) begin
			ovf_seen = 1'b1;
		end else begin
			taken_cnt++;
			if (seg_open || it.height == '0)
				seg_new = 1'b1;
			else
				seg_new = (prev_h % it.height) != '0;
			if (seg_new) begin
				win_head = '0;
				win_len = '0;
				win_sum = '0;
			end
			seg_open = 1'b0;
			prev_h = it.height;
			tail = win_head + win_len[9:0];
			win_vals[tail] = it.value;
			win_len++;
			win_sum = win_sum + 64'(it.value);
			if (win_sum <= 64'(lim)) begin
				if (win_len > best_len)
					best_len = win_len;
			end else begin
				win_sum = win_sum - 64'(win_vals[win_head]);
				win_head++;
				win_len--;
			end
		end
		if (it.last) begin
			res.run = (best_len > slwsl_pkg::RUN_MAX) ? slwsl_pkg::RUN_MAX : best_len;
			res.ovf = ovf_seen;
			expected_runs.insert(expected_runs.size(), res);
			clear_seq();
		end
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_item(cur_item);
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
					cur_item = pending_items.pop_front();
					in_valid <= 1'b1;
					item_value <= cur_item.value;
					item_height <= cur_item.height;
					last_item <= cur_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 23);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_runs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: longest_run %0d overflow %0b",
						longest_run, overflow);
			end else begin
				want_run = expected_runs.pop_front();
				results_checked++;
				if (want_run.ovf)
					ovf_results++;
				if (longest_run !== want_run.run || overflow !== want_run.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: longest_run exp %0d got %0d, overflow exp %0b got %0b",
							want_run.run, longest_run, want_run.ovf, overflow);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_runs.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic add_item(input logic [slwsl_pkg::VALUE_W-1:0] v,
			input logic [slwsl_pkg::HEIGHT_W-1:0] h, input logic last);
		item_t it;
		it.value = v;
		it.height = h;
		it.last = last;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic wait_results();
		while (pending_items.size() > 0 || in_valid || expected_runs.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_limit(input logic [slwsl_pkg::LIMIT_W-1:0] v);
		wait_results();
		repeat (SETTLE) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim = v;
		limits_used++;
		@(negedge clk);
	endtask

	function automatic logic [slwsl_pkg::VALUE_W-1:0] rand_value();
		logic [63:0] cap;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return VALUE_TOP;
			2, 3: return slwsl_pkg::VALUE_W'($urandom);
			default: begin
				cap = 64'(lim) / 64'($urandom_range(1, 6));
				if (cap > 64'(VALUE_TOP))
					cap = 64'(VALUE_TOP);
				return slwsl_pkg::VALUE_W'($urandom_range(0, cap[31:0]));
			end
		endcase
	endfunction

	function automatic logic [slwsl_pkg::HEIGHT_W-1:0] next_height(
			input logic [slwsl_pkg::HEIGHT_W-1:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		else if (r < 20 || prev == '0)
			return slwsl_pkg::HEIGHT_W'($urandom);
		else if (r < 35)
			return prev;
		else if (r < 45)
			return slwsl_pkg::HEIGHT_W'(1);
		else if (r < 55 && prev % 3 == 0)
			return slwsl_pkg::HEIGHT_W'(prev / 3);
		else if (!prev[0])
			return prev >> 1;
		else
			return prev;
	endfunction

	task automatic add_random_seq(inout int count);
		int len;
		logic [slwsl_pkg::HEIGHT_W-1:0] h;
		if ($urandom_range(0, 9) == 0)
			len = $urandom_range(9, 48);
		else
			len = $urandom_range(1, 8);
		if ($urandom_range(0, 4) == 0)
			h = slwsl_pkg::HEIGHT_W'($urandom);
		else
			h = slwsl_pkg::HEIGHT_W'($urandom_range(1, 255)
				* ($urandom_range(0, 1) ? 3 : 1)
				* (32'd1 << $urandom_range(0, 18)));
		if (h == '0)
			h = 1;
		for (int k = 0; k < len; k++) begin
			if (k > 0)
				h = next_height(h);
			add_item(rand_value(), h, k == len - 1);
		end
		count += len;
	endtask

	task automatic random_items(input int n);
		int count;
		count = 0;
		while (count < n)
			add_random_seq(count);
	endtask

	initial begin
		clear_seq();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// limit zero: only zero values fit
		write_limit('0);
		add_item('0, HEIGHT_TOP, 1'b1);
		add_item(VALUE_TOP, 1, 1'b1);
		add_item('0, 6, 1'b0);
		add_item('0, 3, 1'b0);
		add_item(VALUE_TOP, 3, 1'b0);
		add_item('0, 3, 1'b1);

		// widest limit, zero height and a zero previous height
		write_limit(LIMIT_TOP);
		add_item(VALUE_TOP, HEIGHT_TOP, 1'b0);
		add_item(VALUE_TOP, 1, 1'b0);
		add_item(5, 0, 1'b0);
		add_item(5, 7, 1'b0);
		add_item(1, 2, 1'b0);
		add_item(1, 2, 1'b1);

		// small limit: pops inside segments, breaks between them
		write_limit(10);
		add_item(3, 12, 1'b0);
		add_item(4, 6, 1'b0);
		add_item(5, 3, 1'b0);
		add_item(2, 5, 1'b0);
		add_item(9, 5, 1'b0);
		add_item(1, 5, 1'b0);
		add_item(1, 5, 1'b1);

		// long receiver hold-off, then a sender pause mid-phase
		write_limit(1000);
		random_items(40);
		hold_req = 1'b1;
		wait_results();
		random_items(30);

		// one sequence past the item bound
		write_limit(LIMIT_TOP);
		add_item(rand_value(), 720720, 1'b0);
		for (int k = 1; k < MAX_ITEMS + 6; k++)
			add_item(rand_value(), 1, k == MAX_ITEMS + 5);
		random_items(40);

		write_limit(slwsl_pkg::LIMIT_W'({$urandom, $urandom} & 64'(LIMIT_TOP)));
		random_items(40);

		write_limit(slwsl_pkg::LIMIT_W'(64'h0000_8000_0000
			+ 64'($urandom_range(0, 32'h7fff_ffff))));
		quiet = 1'b1;
		random_items(40);
		wait_results();
		quiet = 1'b0;

		write_limit('0);
		random_items(30);

		write_limit(slwsl_pkg::LIMIT_W'(($urandom & 32'h00ff_ffff) + 1));
		random_items(40);

		wait_results();
		repeat (SETTLE) @(negedge clk);
		if (expected_runs.size() != 0)
			mismatches++;
		$display("covered %0d beats in %0d checked sequences (%0d with overflow), %0d limits",
			items_taken, results_checked, ovf_results, limits_used);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
